/* rtl/philox_counter_rng_core_assert.svh */
// ----------------------------------------------------------------------------
// philox_counter_rng_core_assert.svh
// assertion macros shared by the generator core modules
// ----------------------------------------------------------------------------
`ifndef PHILOX_COUNTER_RNG_CORE_ASSERT_SVH
`define PHILOX_COUNTER_RNG_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define PHILOX_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, checked outside reset
`define PHILOX_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PHILOX_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define PHILOX_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

/* rtl/philox_pkg.sv */
// ----------------------------------------------------------------------------
// philox_pkg
// types and constants of the philox4x32 generator core
// ----------------------------------------------------------------------------
package philox_pkg;

  typedef logic [31:0] word_t;

  // four counter or output words, word 0 in the low slot
  typedef word_t [3:0] block_t;

  // the two key words of one round
  typedef struct packed {
    word_t k0;
    word_t k1;
  } key_t;

  // round multipliers
  localparam word_t MULT_A = 32'hD2511F53;
  localparam word_t MULT_B = 32'hCD9E8D57;

  // key schedule increments
  localparam word_t WEYL_A = 32'h9E3779B9;
  localparam word_t WEYL_B = 32'hBB67AE85;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  localparam cfg_index_t REG_KEY_LOW  = 1'b0;
  localparam cfg_index_t REG_KEY_HIGH = 1'b1;

endpackage

/* rtl/philox_keys.sv */
// ----------------------------------------------------------------------------
// philox_keys
// key registers written through the configuration port
// ----------------------------------------------------------------------------
`include "philox_counter_rng_core_assert.svh"

module philox_keys (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  philox_pkg::cfg_index_t  cfg_index,
  input  philox_pkg::word_t       cfg_data,
  output philox_pkg::key_t        key
);

  // writes are taken in any cycle
  assign cfg_ready = 1'b1;

  // key word registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        philox_pkg::REG_KEY_LOW:  key.k0 <= cfg_data;
        philox_pkg::REG_KEY_HIGH: key.k1 <= cfg_data;
        default: key <= key;
      endcase
    end
  end

  `PHILOX_ASSERT_NEXT(a_key_low_write, clk, rst,
    cfg_valid && cfg_ready && cfg_index == philox_pkg::REG_KEY_LOW,
    key.k0 == $past(cfg_data) && $stable(key.k1), "key low write lost")
  `PHILOX_ASSERT_NEXT(a_key_high_write, clk, rst,
    cfg_valid && cfg_ready && cfg_index == philox_pkg::REG_KEY_HIGH,
    key.k1 == $past(cfg_data) && $stable(key.k0), "key high write lost")
  `PHILOX_ASSERT_NEXT(a_key_idle_holds, clk, rst, !(cfg_valid && cfg_ready),
    $stable(key), "key changed without a write")

endmodule

/* rtl/philox_round.sv */
// ----------------------------------------------------------------------------
// philox_round
// one registered philox round: two wide multiplies, key mix and word swap
// ----------------------------------------------------------------------------
`include "philox_counter_rng_core_assert.svh"

module philox_round (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  philox_pkg::block_t  in_block,
  input  philox_pkg::key_t    round_key,
  output logic                out_valid,
  input  logic                out_ready,
  output philox_pkg::block_t  out_block
);

  logic [63:0]        prod_a;
  logic [63:0]        prod_b;
  philox_pkg::block_t block_next;

  // stage takes a request when empty or when its content moves on
  assign in_ready = !out_valid || out_ready;

  // full 64-bit products of words 0 and 2
  assign prod_a = {32'b0, philox_pkg::MULT_A} * {32'b0, in_block[0]};
  assign prod_b = {32'b0, philox_pkg::MULT_B} * {32'b0, in_block[2]};

  // key mix and swap
  always_comb begin
    block_next[0] = prod_b[63:32] ^ in_block[1] ^ round_key.k0;
    block_next[1] = prod_b[31:0];
    block_next[2] = prod_a[63:32] ^ in_block[3] ^ round_key.k1;
    block_next[3] = prod_a[31:0];
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_block <= block_next;
    end
  end

  `PHILOX_ASSERT_NEXT(a_stall_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(out_block), "stalled round stage changed")
  `PHILOX_ASSERT_NOW(a_empty_ready, clk, rst, !out_valid, in_ready, "empty round stage refuses a request")
  `PHILOX_ASSERT_NEXT(a_take_fills, clk, rst, in_valid && in_ready, out_valid, "accepted request dropped")

endmodule

/* rtl/philox_counter_rng_core.sv */
// ----------------------------------------------------------------------------
// philox_counter_rng_core
// pipeline: one register per round between request and result
// throughput: one request per cycle while out_ready is high; bubbles close up
// reset: clears the stage valid bits and both key words; stage data is kept
// ----------------------------------------------------------------------------
module philox_counter_rng_core #(
  parameter int unsigned ROUND_COUNT = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  philox_pkg::cfg_index_t  cfg_index,
  input  philox_pkg::word_t       cfg_data,
  // counter requests
  input  logic                    in_valid,
  output logic                    in_ready,
  input  philox_pkg::word_t       count_word0,
  input  philox_pkg::word_t       count_word1,
  input  philox_pkg::word_t       count_word2,
  input  philox_pkg::word_t       count_word3,
  // random words
  output logic                    out_valid,
  input  logic                    out_ready,
  output philox_pkg::word_t       rand_word0,
  output philox_pkg::word_t       rand_word1,
  output philox_pkg::word_t       rand_word2,
  output philox_pkg::word_t       rand_word3
);

  philox_pkg::key_t   key;
  philox_pkg::block_t stage_block [ROUND_COUNT+1];
  logic [ROUND_COUNT:0] stage_valid;
  logic [ROUND_COUNT:0] stage_ready;

  // key registers
  philox_keys u_keys (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key)
  );

  // pipeline entry
  assign stage_valid[0] = in_valid;
  assign in_ready       = stage_ready[0];
  assign stage_block[0] = {count_word3, count_word2, count_word1, count_word0};

  // round stages, each with its own scheduled key
  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    localparam philox_pkg::word_t OFF_A = 32'(64'(philox_pkg::WEYL_A) * 64'(r));
    localparam philox_pkg::word_t OFF_B = 32'(64'(philox_pkg::WEYL_B) * 64'(r));

    philox_pkg::key_t round_key;

    assign round_key.k0 = key.k0 + OFF_A;
    assign round_key.k1 = key.k1 + OFF_B;

    philox_round u_round (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[r]),
      .in_ready  (stage_ready[r]),
      .in_block  (stage_block[r]),
      .round_key (round_key),
      .out_valid (stage_valid[r+1]),
      .out_ready (stage_ready[r+1]),
      .out_block (stage_block[r+1])
    );
  end

  // pipeline exit
  assign out_valid               = stage_valid[ROUND_COUNT];
  assign stage_ready[ROUND_COUNT] = out_ready;
  assign rand_word0 = stage_block[ROUND_COUNT][0];
  assign rand_word1 = stage_block[ROUND_COUNT][1];
  assign rand_word2 = stage_block[ROUND_COUNT][2];
  assign rand_word3 = stage_block[ROUND_COUNT][3];

endmodule
